@@ hdl/eivs_pkg.sv @@
// Package: payload types and constants for the eroding interface velocity solver
`timescale 1ns / 1ps
package eivs_pkg;

	localparam int VW = 22;
	localparam int DW = 15;
	localparam int SW = 35;
	localparam int DISC_W = 76;
	localparam int ROOT_W = 39;
	localparam int NUM_W = 61;
	localparam int QW = 38;

	typedef enum logic [2:0] {
		CASE_LINEAR = 3'd0,
		CASE_LIN_DEGEN = 3'd1,
		CASE_NO_ROOT = 3'd2,
		CASE_BOTH = 3'd3,
		CASE_FIRST = 3'd4,
		CASE_SECOND = 3'd5,
		CASE_NONE = 3'd6
	} result_case_t;

	typedef struct packed {
		logic [VW-1:0] impact_speed;
		logic [DW-1:0] proj_density;
		logic [DW-1:0] target_density;
		logic [SW-1:0] proj_strength;
		logic [SW-1:0] target_resistance;
	} in_item_t;

	typedef struct packed {
		logic [VW-1:0] interface_speed;
		logic [2:0] result_case;
	} out_item_t;

endpackage

@@ hdl/eivs_isqrt.sv @@
// Pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
module eivs_isqrt #(
	parameter int TW = 8
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [eivs_pkg::DISC_W-1:0] rad,
	input  logic [TW-1:0]               tag_in,
	output logic [eivs_pkg::ROOT_W-1:0] root,
	output logic [TW-1:0]               tag_out
);
	import eivs_pkg::*;

	localparam int RW = ROOT_W + 3;
	localparam int XW = 2 * ROOT_W;

	logic [DISC_W-1:0] rad_c [0:ROOT_W];
	logic [RW-1:0]     rem_c [0:ROOT_W];
	logic [ROOT_W-1:0] acc_c [0:ROOT_W];
	logic [TW-1:0]     tag_c [0:ROOT_W];

	assign rad_c[0] = rad;
	assign rem_c[0] = '0;
	assign acc_c[0] = '0;
	assign tag_c[0] = tag_in;

	// remainder recurrence: bring down two radicand bits, try 4*root+1
	for (genvar g = 0; g < ROOT_W; g++) begin : g_bit
		logic [XW-1:0] radx;
		logic [RW-1:0] cur;
		logic [RW-1:0] trial;
		logic fit;
		logic [DISC_W-1:0] rad_q;
		logic [RW-1:0] rem_q;
		logic [ROOT_W-1:0] acc_q;
		logic [TW-1:0] tag_q;
		assign radx = XW'(rad_c[g]);
		assign cur = {rem_c[g][RW-3:0], radx[XW-1-2*g -: 2]};
		assign trial = RW'({acc_c[g], 2'b01});
		assign fit = cur >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				rad_q <= rad_c[g];
				tag_q <= tag_c[g];
				rem_q <= fit ? cur - trial : cur;
				acc_q <= {acc_c[g][ROOT_W-2:0], fit};
			end
		end
		assign rad_c[g+1] = rad_q;
		assign rem_c[g+1] = rem_q;
		assign acc_c[g+1] = acc_q;
		assign tag_c[g+1] = tag_q;
	end

	assign root = acc_c[ROOT_W];
	assign tag_out = tag_c[ROOT_W];
endmodule

@@ hdl/eroding_interface_velocity_solver.sv @@
// Top level: pipelined Tate-Bernoulli interface speed solver
//  channel | signals                      | payload
//  in      | in_valid / in_ready / in_item  | eivs_pkg::in_item_t
//  out     | out_valid / out_ready / out_item | eivs_pkg::out_item_t
// One item enters per cycle whenever the pipe advances; the pipe holds three
// product and discriminant stages, one per root bit, one setup stage, QSTEP per
// quotient bit and the output register. arst_n clears all valid bits.
// The whole pipe advances only when its last stage is empty or being taken,
// so a stall freezes every stage and nothing is lost or repeated.
`timescale 1ns / 1ps
module eroding_interface_velocity_solver #(
	parameter int QSTEP = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  eivs_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output eivs_pkg::out_item_t out_item
);
	import eivs_pkg::*;

	localparam int NSTG = 5 + ROOT_W + QW * QSTEP;

	logic en;
	logic [NSTG-1:0] vld_q;
	assign en = !vld_q[NSTG-1] || out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[NSTG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NSTG-2:0], in_valid};
		end
	end

	// stage 1: products
	typedef struct packed {
		logic [VW-1:0] v;
		logic lin;
		logic degen;
		logic apos;
		logic [DW-1:0] amag;
		logic kpos_d;
		logic [SW-1:0] dmag;
		logic [29:0] rprt;
		logic [43:0] vv2;
		logic [DW+VW-1:0] base;
	} s1_t;
	s1_t s1;
	always_ff @(posedge clk) begin
		if (en) begin
			s1.v <= in_item.impact_speed;
			s1.lin <= in_item.proj_density == in_item.target_density;
			s1.degen <= in_item.proj_density == '0 || in_item.impact_speed == '0;
			s1.apos <= in_item.proj_density > in_item.target_density;
			s1.amag <= (in_item.proj_density > in_item.target_density) ?
				in_item.proj_density - in_item.target_density :
				in_item.target_density - in_item.proj_density;
			s1.kpos_d <= in_item.target_resistance > in_item.proj_strength;
			s1.dmag <= (in_item.target_resistance > in_item.proj_strength) ?
				in_item.target_resistance - in_item.proj_strength :
				in_item.proj_strength - in_item.target_resistance;
			s1.rprt <= 30'(in_item.proj_density) * 30'(in_item.target_density);
			s1.vv2 <= 44'(in_item.impact_speed) * 44'(in_item.impact_speed);
			s1.base <= 37'(in_item.proj_density) * 37'(in_item.impact_speed);
		end
	end

	// stage 2: P = rprt*vv2 as two halves, QK = amag*dmag<<17, linear numerator
	typedef struct packed {
		logic [VW-1:0] v;
		logic lin;
		logic degen;
		logic apos;
		logic [DW-1:0] amag;
		logic [DW+VW-1:0] base;
		logic [51:0] pl;
		logic [51:0] ph;
		logic [DISC_W-1:0] qk;
		logic kpos;
		logic [60:0] rpvv;
		logic kpos_d;
		logic [52:0] k;
	} s2_t;
	s2_t s2;
	always_ff @(posedge clk) begin
		if (en) begin
			s2.v <= s1.v;
			s2.lin <= s1.lin;
			s2.degen <= s1.degen;
			s2.apos <= s1.apos;
			s2.amag <= s1.amag;
			s2.base <= s1.base;
			s2.pl <= 52'(s1.rprt) * 52'(s1.vv2[21:0]);
			s2.ph <= 52'(s1.rprt) * 52'(s1.vv2[43:22]);
			s2.qk <= DISC_W'({s1.amag, 17'd0}) * DISC_W'(s1.dmag);
			s2.kpos <= s1.dmag != '0 && (s1.apos == s1.kpos_d);
			s2.rpvv <= 61'(s1.base) * 61'(s1.v);
			s2.kpos_d <= s1.kpos_d;
			s2.k <= {1'b0, s1.dmag, 17'd0};
		end
	end

	// stage 3: discriminant or linear numerator; set up quotient operands
	typedef struct packed {
		logic [VW-1:0] v;
		logic lin;
		logic degen;
		logic neg;
		logic apos;
		logic [DW+VW-1:0] base;
		logic [DW-1:0] amag;
		logic [62:0] c;
		logic cpos;
	} tag_t;
	tag_t s3;
	logic [DISC_W-1:0] d_s3;
	logic [62:0] csum;
	logic [DISC_W:0] dsum;
	always_comb begin
		if (s2.kpos_d) csum = 63'(s2.rpvv) - 63'(s2.k);
		else csum = 63'(s2.rpvv) + 63'(s2.k);
	end
	always_comb begin
		if (s2.kpos)
			dsum = (DISC_W+1)'(s2.pl) + (DISC_W+1)'({s2.ph, 22'd0}) +
				(DISC_W+1)'(s2.qk);
		else
			dsum = (DISC_W+1)'(s2.pl) + (DISC_W+1)'({s2.ph, 22'd0}) -
				(DISC_W+1)'(s2.qk);
	end
	always_ff @(posedge clk) begin
		if (en) begin
			s3.v <= s2.v;
			s3.lin <= s2.lin;
			s3.degen <= s2.degen;
			s3.apos <= s2.apos;
			s3.base <= s2.base;
			s3.amag <= s2.amag;
			s3.c <= csum;
			s3.cpos <= !csum[62] && csum != '0;
			s3.neg <= !s2.kpos && dsum[DISC_W];
			d_s3 <= dsum[DISC_W-1:0];
		end
	end

	logic [ROOT_W-1:0] s_root;
	tag_t s4;
	eivs_isqrt #(.TW($bits(tag_t))) u_sqrt (
		.clk(clk), .en(en),
		.rad(d_s3), .tag_in(s3), .root(s_root), .tag_out(s4)
	);

	// stage 5: numerators and divisors for both roots (or linear case)
	// n1 = base+s, n2 = base-s (signed); divisor amag; sign flipped when a<0
	typedef struct packed {
		tag_t t;
		logic ok1;
		logic ok2;
		logic [NUM_W-1:0] n1;
		logic [NUM_W-1:0] n2;
		logic [NUM_W-1:0] dv;
	} s5_t;
	s5_t s5;
	logic signed [40:0] n1w, n2w, n1a, n2a;
	logic signed [40:0] lim;
	always_comb begin
		n1w = 41'(s4.base) + 41'(s_root);
		n2w = 41'(s4.base) - 41'(s_root);
		n1a = s4.apos ? n1w : -n1w;
		n2a = s4.apos ? n2w : -n2w;
		lim = 41'(s4.v) * 41'(s4.amag);
	end
	always_ff @(posedge clk) begin
		if (en) begin
			s5.t <= s4;
			s5.ok1 <= !n1a[40] && n1a <= lim;
			s5.ok2 <= !n2a[40] && n2a <= lim;
			if (s4.lin) begin
				s5.n1 <= NUM_W'(s4.c);
				s5.n2 <= '0;
				s5.dv <= NUM_W'({s4.base, 1'b0});
			end else begin
				s5.n1 <= NUM_W'(n1a[39:0]);
				s5.n2 <= NUM_W'(n2a[39:0]);
				s5.dv <= NUM_W'(s4.amag);
			end
		end
	end

	// restoring dividers, QSTEP stages per quotient bit
	localparam int DWD = NUM_W;
	logic [DWD-1:0] r1 [0:QW];
	logic [DWD-1:0] r2 [0:QW];
	logic [QW-1:0] q1 [0:QW];
	logic [QW-1:0] q2 [0:QW];
	logic [DWD-1:0] dvp [0:QW];
	s5_t tg [0:QW];
	assign r1[0] = s5.n1;
	assign r2[0] = s5.n2;
	assign q1[0] = '0;
	assign q2[0] = '0;
	assign dvp[0] = s5.dv;
	assign tg[0] = s5;
	for (genvar g = 0; g < QW; g++) begin : g_div
		localparam int SH = QW - 1 - g;
		logic [2*DWD-1:0] sd;
		logic t1, t2;
		logic [DWD-1:0] r1n, r2n;
		logic [QW-1:0] q1n, q2n;
		logic [DWD-1:0] r1p [0:QSTEP-1];
		logic [DWD-1:0] r2p [0:QSTEP-1];
		logic [QW-1:0] q1p [0:QSTEP-1];
		logic [QW-1:0] q2p [0:QSTEP-1];
		logic [DWD-1:0] dp [0:QSTEP-1];
		s5_t tp [0:QSTEP-1];
		assign sd = (2*DWD)'(dvp[g]) << SH;
		assign t1 = (2*DWD)'(r1[g]) >= sd;
		assign t2 = (2*DWD)'(r2[g]) >= sd;
		assign r1n = t1 ? r1[g] - DWD'(sd) : r1[g];
		assign r2n = t2 ? r2[g] - DWD'(sd) : r2[g];
		assign q1n = q1[g] | (QW'(t1) << SH);
		assign q2n = q2[g] | (QW'(t2) << SH);
		for (genvar k = 0; k < QSTEP; k++) begin : g_stg
			if (k == 0) begin : g_first
				always_ff @(posedge clk) begin
					if (en) begin
						r1p[k] <= r1n; r2p[k] <= r2n; q1p[k] <= q1n; q2p[k] <= q2n;
						dp[k] <= dvp[g]; tp[k] <= tg[g];
					end
				end
			end else begin : g_next
				always_ff @(posedge clk) begin
					if (en) begin
						r1p[k] <= r1p[k-1]; r2p[k] <= r2p[k-1];
						q1p[k] <= q1p[k-1]; q2p[k] <= q2p[k-1];
						dp[k] <= dp[k-1]; tp[k] <= tp[k-1];
					end
				end
			end
		end
		assign r1[g+1] = r1p[QSTEP-1];
		assign r2[g+1] = r2p[QSTEP-1];
		assign q1[g+1] = q1p[QSTEP-1];
		assign q2[g+1] = q2p[QSTEP-1];
		assign dvp[g+1] = dp[QSTEP-1];
		assign tg[g+1] = tp[QSTEP-1];
	end

	// final stage: select result
	s5_t tf;
	logic [QW-1:0] qa, qb;
	out_item_t res;
	assign tf = tg[QW];
	assign qa = q1[QW];
	assign qb = q2[QW];
	always_comb begin
		res.interface_speed = '0;
		res.result_case = CASE_NONE;
		if (tf.t.lin) begin
			if (tf.t.degen) begin
				res.result_case = CASE_LIN_DEGEN;
			end else begin
				res.result_case = CASE_LINEAR;
				if (tf.t.cpos)
					res.interface_speed = (qa > QW'(tf.t.v)) ? tf.t.v : VW'(qa);
			end
		end else if (tf.t.neg) begin
			res.result_case = CASE_NO_ROOT;
		end else if (tf.ok1 && tf.ok2) begin
			res.result_case = CASE_BOTH;
			res.interface_speed = (qa < qb) ? VW'(qa) : VW'(qb);
		end else if (tf.ok1) begin
			res.result_case = CASE_FIRST;
			res.interface_speed = VW'(qa);
		end else if (tf.ok2) begin
			res.result_case = CASE_SECOND;
			res.interface_speed = VW'(qb);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_item <= res;
		end
	end
endmodule

@@ test/tb.sv @@
// Testbench: randomized and directed checks of the eroding interface speed solver
`timescale 1ns / 1ps
module tb;
	import eivs_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_item;

	out_item_t pending_speeds[$];
	int errors = 0;
	int quiet_cycles = 0;
	int ready_hold = 0;
	bit no_idle = 1'b0;

	eroding_interface_velocity_solver dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	always #2 clk = ~clk;

	function automatic bit root_fits(longint n, longint a, longint vv, output longint q);
		q = 0;
		if (a < 0) begin
			n = -n;
			a = -a;
		end
		if (n < 0 || n > vv * a)
			return 1'b0;
		q = n / a;
		return 1'b1;
	endfunction

	function automatic out_item_t solve_interface(in_item_t it);
		longint vv, rp, rt, yp, rr, a, diff, spd, c, base, s, q1, q2, amag, kmag;
		logic [127:0] p, qk, d, t;
		bit kpos, ok1, ok2;
		result_case_t k;
		out_item_t r;
		vv = longint'(it.impact_speed);
		rp = longint'(it.proj_density);
		rt = longint'(it.target_density);
		yp = longint'(it.proj_strength);
		rr = longint'(it.target_resistance);
		a = rp - rt;
		diff = rr - yp;
		spd = 0;
		if (a == 0) begin
			if (rp == 0 || vv == 0) begin
				k = CASE_LIN_DEGEN;
			end else begin
				k = CASE_LINEAR;
				c = rp * vv * vv - diff * 131072;
				if (c > 0) begin
					spd = c / (2 * rp * vv);
					if (spd > vv)
						spd = vv;
				end
			end
		end else begin
			p = 128'(rp * rt) * 128'(vv * vv);
			amag = a < 0 ? -a : a;
			kmag = (diff < 0 ? -diff : diff) << 17;
			qk = 128'(amag) * 128'(kmag);
			kpos = (a > 0 && diff > 0) || (a < 0 && diff < 0);
			if (!kpos && p < qk) begin
				k = CASE_NO_ROOT;
			end else begin
				d = kpos ? p + qk : p - qk;
				s = 0;
				for (int b = 38; b >= 0; b--) begin
					t = 128'(s | (longint'(1) << b));
					if (t * t <= d)
						s = longint'(t);
				end
				base = rp * vv;
				ok1 = root_fits(base + s, a, vv, q1);
				ok2 = root_fits(base - s, a, vv, q2);
				if (ok1 && ok2) begin
					k = CASE_BOTH;
					spd = q1 < q2 ? q1 : q2;
				end else if (ok1) begin
					k = CASE_FIRST;
					spd = q1;
				end else if (ok2) begin
					k = CASE_SECOND;
					spd = q2;
				end else begin
					k = CASE_NONE;
				end
			end
		end
		r.interface_speed = spd[VW-1:0];
		r.result_case = k;
		return r;
	endfunction

	task automatic send_request(in_item_t it);
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_speeds.push_back(solve_interface(it));
		if (!no_idle && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	function automatic in_item_t make_item(int unsigned v, int unsigned rp, int unsigned rt,
			longint unsigned yp, longint unsigned rr);
		in_item_t it;
		it.impact_speed = v[VW-1:0];
		it.proj_density = rp[DW-1:0];
		it.target_density = rt[DW-1:0];
		it.proj_strength = yp[SW-1:0];
		it.target_resistance = rr[SW-1:0];
		return it;
	endfunction

	function automatic longint unsigned rand_strength();
		longint unsigned x;
		x = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: return x & 64'h7_FFFF_FFFF;
			1: return x & ((64'd1 << $urandom_range(0, 35)) - 1);
			2: return 64'd0;
			default: return $urandom_range(0, 2000) * 64'd1000000;
		endcase
	endfunction

	// extremes and degenerate densities
	task automatic test_extremes();
		send_request(make_item(0, 0, 0, 0, 0));
		send_request(make_item(4194303, 32767, 32767, 64'h7_FFFF_FFFF, 64'h7_FFFF_FFFF));
		send_request(make_item(4194303, 32767, 32767, 0, 0));
		send_request(make_item(4194303, 32767, 32767, 64'h7_FFFF_FFFF, 0));
		send_request(make_item(0, 500, 500, 100, 5));
		send_request(make_item(1000, 0, 0, 100, 5));
		send_request(make_item(4194303, 32767, 0, 0, 64'h7_FFFF_FFFF));
		send_request(make_item(4194303, 0, 32767, 64'h7_FFFF_FFFF, 0));
		send_request(make_item(4194303, 32767, 1, 64'h7_FFFF_FFFF, 0));
		send_request(make_item(1, 1, 32767, 0, 64'h7_FFFF_FFFF));
	endtask

	// physical cases across the linear and root outcomes
	task automatic test_root_cases();
		send_request(make_item(256000, 7800, 2700, 1000000000, 3000000000));
		send_request(make_item(256000, 2700, 7800, 1000000000, 3000000000));
		send_request(make_item(512000, 19000, 7800, 2000000000, 4000000000));
		send_request(make_item(512000, 7800, 19000, 4000000000, 2000000000));
		send_request(make_item(25600, 7800, 7850, 1000000000, 5000000000));
		send_request(make_item(25600, 7850, 7800, 5000000000, 1000000000));
		send_request(make_item(256000, 7800, 7800, 1000000000, 3000000000));
		send_request(make_item(256000, 7800, 7800, 3000000000, 1000000000));
		send_request(make_item(2560, 7800, 7800, 0, 64'h7_FFFF_FFFF));
		send_request(make_item(4194303, 1, 2, 0, 1));
		send_request(make_item(300, 10, 20, 0, 0));
		send_request(make_item(300, 20, 10, 0, 0));
	endtask

	task automatic test_random(int count);
		int unsigned v, rp, rt;
		for (int i = 0; i < count; i++) begin
			no_idle = (i >= count - 120);
			v = $urandom_range(0, 3) == 0 ? $urandom & 32'h3F_FFFF : $urandom_range(0, 1024000);
			rp = $urandom_range(0, 7) == 0 ? $urandom & 32'h7FFF : $urandom_range(1000, 20000);
			rt = $urandom_range(0, 3) == 0 ? rp : ($urandom_range(0, 7) == 0 ?
				$urandom & 32'h7FFF : $urandom_range(1000, 20000));
			send_request(make_item(v, rp, rt, rand_strength(), rand_strength()));
		end
	endtask

	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
			if (ready_hold == 0)
				out_ready <= 1'b1;
		end else if (!no_idle && arst_n && $urandom_range(0, 9) == 0) begin
			out_ready <= 1'b0;
			ready_hold = $urandom_range(1, 17);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (out_valid && out_ready) begin
			if (pending_speeds.size() == 0) begin
				errors++;
				$display("%0t: unexpected result speed=%0d case=%0d", $time,
					out_item.interface_speed, out_item.result_case);
			end else begin
				want = pending_speeds.pop_front();
				if (out_item.interface_speed !== want.interface_speed) begin
					errors++;
					$display("%0t: interface_speed expected %0d actual %0d", $time,
						want.interface_speed, out_item.interface_speed);
				end
				if (out_item.result_case !== want.result_case) begin
					errors++;
					$display("%0t: result_case expected %0d actual %0d", $time,
						want.result_case, out_item.result_case);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_root_cases();
		test_random(630);
		in_valid <= 1'b0;
		while (pending_speeds.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

@@ files.f @@
hdl/eivs_pkg.sv
hdl/eivs_isqrt.sv
hdl/eroding_interface_velocity_solver.sv
test/tb.sv
